// File: rtl/b64u_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

  localparam int CHAR_W   = 8;
  localparam int SEXTET_W = 6;
  localparam int LEN_W    = 15;
  localparam int STATUS_W = 3;

  // hard ceiling on bytes per stream, and the counter's own ceiling
  localparam int MAX_BYTES = 16384;
  localparam int CNT_CEIL  = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LIMIT_CAP =
    LEN_W'((MAX_BYTES > CNT_CEIL) ? CNT_CEIL : MAX_BYTES);

  localparam logic [LEN_W-1:0] CAPACITY_RST = LEN_W'(16384);

  // alphabet offsets
  localparam logic [SEXTET_W-1:0] LOWER_BASE = 6'd26;
  localparam logic [SEXTET_W-1:0] DIGIT_BASE = 6'd52;
  localparam logic [SEXTET_W-1:0] DASH_CODE  = 6'd62;
  localparam logic [SEXTET_W-1:0] UNDER_CODE = 6'd63;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_OVER_CAP = 3'd2,
    ST_LEN_MOD4 = 3'd3,
    ST_LEFTOVER = 3'd4
  } status_t;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        data_byte;
    logic              stream_done;
    status_t           status;
    logic [LEN_W-1:0]  decoded_length;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/base64url_canonical_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// base64url decoder, unpadded, canonical checks
// input channel: one character request per cycle (in_char_byte, in_last_char)
//   with in_valid / in_stall; a request is taken when in_valid is high and
//   in_stall is low
// result channel: exactly one result request per character on out_*,
//   out_valid / out_stall; byte output only when out_byte_valid is set
// path: a character passes the input register, then the result register;
//   throughput: one character per clock while the receiver does not stall, set by
//   the single decode/update stage between the two registers
// the decode stage advances whenever the result register is empty or being
//   drained, so a stalled receiver holds the result and backs up in_stall
//   after the input register fills
// errors are sticky within a stream and reported with the length on the
//   last character's result; stream state then clears
// cfg: one register, output capacity, written at cfg_valid && cfg_ready;
//   cfg_ready is always high; write only while the block is idle
// reset (rst_n low, synchronous): pipeline empties, stream state clears,
//   capacity returns to 16384

module base64url_canonical_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [b64u_pkg::CHAR_W-1:0]   in_char_byte,
  input  wire logic                          in_last_char,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_byte_valid,
  output logic      [7:0]                    out_data_byte,
  output logic                               out_stream_done,
  output logic      [b64u_pkg::STATUS_W-1:0] out_status,
  output logic      [b64u_pkg::LEN_W-1:0]    out_decoded_length,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [b64u_pkg::LEN_W-1:0]    cfg_output_capacity
);
  import b64u_pkg::*;

  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;
  logic [LEN_W-1:0]  cap_r;
  logic              out_valid_r;
  res_t              res, res_r;
  logic              out_free;
  logic              step;

  // result register can take a new request this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_output_capacity;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_char_r <= in_char_byte;
      in_last_r <= in_last_char;
    end
  end

  // decode and stream state update
  b64u_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_byte (in_char_r),
    .last_char (in_last_r),
    .capacity  (cap_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_valid     = res_r.byte_valid;
  assign out_data_byte      = res_r.data_byte;
  assign out_stream_done    = res_r.stream_done;
  assign out_status         = res_r.status;
  assign out_decoded_length = res_r.decoded_length;

endmodule

`default_nettype wire

// File: rtl/b64u_sextet.sv
`timescale 1ns / 1ps
`default_nettype none

module b64u_sextet (
  input  wire logic [b64u_pkg::CHAR_W-1:0]   char_byte,
  output logic      [b64u_pkg::SEXTET_W-1:0] sextet,
  output logic                               bad
);
  import b64u_pkg::*;

  always_comb begin
    sextet = '0;
    bad    = 1'b0;
    if (char_byte >= "A" && char_byte <= "Z") begin
      sextet = SEXTET_W'(char_byte - "A");
    end else if (char_byte >= "a" && char_byte <= "z") begin
      sextet = SEXTET_W'(char_byte - "a") + LOWER_BASE;
    end else if (char_byte >= "0" && char_byte <= "9") begin
      sextet = SEXTET_W'(char_byte - "0") + DIGIT_BASE;
    end else if (char_byte == "-") begin
      sextet = DASH_CODE;
    end else if (char_byte == "_") begin
      sextet = UNDER_CODE;
    end else begin
      bad = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64u_core.sv
`timescale 1ns / 1ps
`default_nettype none

module b64u_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [b64u_pkg::CHAR_W-1:0]   char_byte,
  input  wire logic                          last_char,
  input  wire logic [b64u_pkg::LEN_W-1:0]    capacity,
  output b64u_pkg::res_t                     res
);
  import b64u_pkg::*;

  logic [SEXTET_W-1:0] left_r,  left_nxt;
  logic [2:0]          cnt_r,   cnt_nxt;
  logic [LEN_W-1:0]    bytes_r, bytes_nxt;
  status_t             err_r,   err_nxt;

  logic [SEXTET_W-1:0] sextet;
  logic                bad;
  logic [LEN_W-1:0]    limit;
  logic [11:0]         acc;
  logic [3:0]          bits;
  logic [2:0]          rem;
  logic                emit;
  logic [7:0]          data;

  b64u_sextet u_sextet (
    .char_byte (char_byte),
    .sextet    (sextet),
    .bad       (bad)
  );

  assign limit = (capacity < LIMIT_CAP) ? capacity : LIMIT_CAP;
  assign acc   = {left_r, sextet};
  assign bits  = {1'b0, cnt_r} + 4'd6;
  assign rem   = (bits >= 4'd8) ? 3'(bits - 4'd8) : 3'(bits);

  always_comb begin
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    data      = '0;
    if (err_r == ST_OK) begin
      if (bad) begin
        err_nxt = ST_BAD_CHAR;
      end else begin
        if (bits >= 4'd8) begin
          if (bytes_r >= limit) begin
            err_nxt = ST_OVER_CAP;
          end else begin
            emit      = 1'b1;
            data      = 8'(acc >> rem);
            bytes_nxt = bytes_r + 1'b1;
          end
        end
        if (err_nxt == ST_OK) begin
          left_nxt = acc[SEXTET_W-1:0] & SEXTET_W'((7'd1 << rem) - 7'd1);
          cnt_nxt  = rem;
        end
      end
      if (last_char && err_nxt == ST_OK) begin
        if (cnt_nxt == 3'd6) begin
          err_nxt = ST_LEN_MOD4;
        end else if (left_nxt != '0) begin
          err_nxt = ST_LEFTOVER;
        end
      end
    end
  end

  always_comb begin
    res.byte_valid     = emit;
    res.data_byte      = data;
    res.stream_done    = last_char;
    res.status         = err_nxt;
    res.decoded_length = bytes_nxt;
  end

  // stream state clears after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      cnt_r   <= '0;
      bytes_r <= '0;
      err_r   <= ST_OK;
    end else if (step) begin
      if (last_char) begin
        left_r  <= '0;
        cnt_r   <= '0;
        bytes_r <= '0;
        err_r   <= ST_OK;
      end else begin
        left_r  <= left_nxt;
        cnt_r   <= cnt_nxt;
        bytes_r <= bytes_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire
